FILE: design/tcphp_pkg.sv
package tcphp_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned MAX_SEG_BYTES_DEF = 65535;
    localparam int unsigned QUEUE_DEPTH_DEF   = 2;

    // Fixed TCP header layout
    localparam logic [15:0] FIXED_HDR_BYTES = 16'd20;
    localparam logic [5:0]  FIXED_HDR_SHORT = 6'd20;
    localparam logic [3:0]  MIN_OFFSET_WORDS = 4'd5;

    // Configuration register map (word index = paddr[2])
    localparam logic       REG_MAX_HDR       = 1'b0;
    localparam logic [5:0] MAX_HDR_RESET     = 6'd60;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TOO_SHORT  = 2'd1,
        ST_BAD_HEADER = 2'd2
    } status_t;

    // One finished segment, as handed from the capture side to the evaluation side
    typedef struct packed {
        logic [15:0] total;
        logic [31:0] ports;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [11:0] off_flags;
        logic [31:0] win_csum;
        logic [15:0] urgent;
    } seg_rec_t;

    // Queue handshake status
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // Result item
    typedef struct packed {
        status_t     status;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] sequence_number;
        logic [31:0] ack_number;
        logic [3:0]  offset_words;
        logic [7:0]  flag_bits;
        logic [15:0] window_size;
        logic [15:0] header_checksum;
        logic [15:0] urgent_pointer;
        logic [5:0]  options_bytes;
        logic [15:0] payload_bytes;
    } result_t;

endpackage

FILE: design/tcp_header_parser.sv
// TCP header parser. Bytes of a TCP segment stream in on s_tdata, one per
// transfer, with s_tlast on the final byte. The block captures the 20-byte
// fixed header and counts the segment length (saturating at
// MAX_SEGMENT_BYTES); for every segment it emits exactly one result transfer
// on the m_ side, with status on m_tuser and all header fields plus the
// options and payload lengths on m_tdata. Status: ok, too_short (segment
// under 20 bytes, all other fields zero; or segment shorter than the header
// length) or bad_header (offset below 5 words or header longer than
// max_header_bytes). Rate: one byte per clock while s_tready is high, with no
// gap between segments; a segment's record enters the queue as its last byte
// is taken, and m_tvalid rises once the output register loads that record,
// at up to one result per clock. The capture side and the evaluation
// side are joined by a QUEUE_DEPTH-entry record queue; s_tready drops only
// while that queue is full, i.e. after m_tready has been held low long enough
// for QUEUE_DEPTH results to back up behind the output register.
// max_header_bytes sits at byte address 0 of the APB port (reset 60) and is
// to be written only while no segment is in flight.
module tcp_header_parser #(
    parameter int unsigned MAX_SEGMENT_BYTES = tcphp_pkg::MAX_SEG_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH       = tcphp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,

    // byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] seg_byte
    input  logic         s_tlast,   // last_byte

    // result out
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] source_port, [31:16] dest_port, [63:32] sequence_number,
    // [95:64] ack_number, [99:96] offset_words, [107:100] flag_bits,
    // [123:108] window_size, [139:124] header_checksum,
    // [155:140] urgent_pointer, [161:156] options_bytes,
    // [177:162] payload_bytes, [183:178] zero
    output logic [183:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] status

    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tcphp_pkg::*;

    logic       rd_sel;
    logic [5:0] max_hdr_q_reg;
    logic [5:0] max_hdr_next;
    logic       cfg_write;

    logic       in_accept;
    logic       push;
    seg_rec_t   push_rec;
    seg_rec_t   head_rec;
    q_stat_t    q_stat;
    logic       pop;
    result_t    result;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        max_hdr_next = max_hdr_q_reg;
        if (cfg_write && paddr[2] == REG_MAX_HDR) begin
            max_hdr_next = pwdata[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_hdr_q_reg <= MAX_HDR_RESET;
        end else begin
            max_hdr_q_reg <= max_hdr_next;
        end
    end

    // readback select
    assign rd_sel = (paddr[2] == REG_MAX_HDR);
    assign prdata = rd_sel ? {26'd0, max_hdr_q_reg} : 32'd0;

    // ---------------- front: byte capture ----------------
    assign s_tready  = ~q_stat.full;
    assign in_accept = s_tvalid & s_tready;

    tcphp_front #(
        .MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push),
        .rec       (push_rec)
    );

    // ---------------- segment record queue ----------------
    tcphp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_rec),
        .pop       (pop),
        .pop_data  (head_rec),
        .stat      (q_stat)
    );

    // ---------------- back: status and lengths ----------------
    tcphp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (~q_stat.empty),
        .rec       (head_rec),
        .max_hdr   (max_hdr_q_reg),
        .out_ready (m_tready),
        .pop       (pop),
        .out_valid (m_tvalid),
        .result    (result)
    );

    assign m_tuser = result.status;
    assign m_tdata = {6'd0,
                      result.payload_bytes,
                      result.options_bytes,
                      result.urgent_pointer,
                      result.header_checksum,
                      result.window_size,
                      result.flag_bits,
                      result.offset_words,
                      result.ack_number,
                      result.sequence_number,
                      result.dest_port,
                      result.source_port};

endmodule

FILE: design/tcphp_front.sv
module tcphp_front #(
    parameter int unsigned MAX_SEGMENT_BYTES = tcphp_pkg::MAX_SEG_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output logic               push,
    output tcphp_pkg::seg_rec_t rec
);
    import tcphp_pkg::*;

    localparam logic [15:0] MAX_SEG = 16'(MAX_SEGMENT_BYTES);

    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    seg_rec_t    cap_reg;
    seg_rec_t    cap_next;

    // Fold the current byte into the header captures
    always_comb begin
        cap_next = cap_reg;
        if (pos_reg < 16'd4) begin
            cap_next.ports = {cap_reg.ports[23:0], in_byte};
        end else if (pos_reg < 16'd8) begin
            cap_next.seq = {cap_reg.seq[23:0], in_byte};
        end else if (pos_reg < 16'd12) begin
            cap_next.ack = {cap_reg.ack[23:0], in_byte};
        end else if (pos_reg == 16'd12) begin
            cap_next.off_flags = {in_byte[7:4], cap_reg.off_flags[7:0]};
        end else if (pos_reg == 16'd13) begin
            cap_next.off_flags = {cap_reg.off_flags[11:8], in_byte};
        end else if (pos_reg < 16'd18) begin
            cap_next.win_csum = {cap_reg.win_csum[23:0], in_byte};
        end else if (pos_reg < FIXED_HDR_BYTES) begin
            cap_next.urgent = {cap_reg.urgent[7:0], in_byte};
        end
        // saturating length including this byte
        cap_next.total = (pos_reg >= MAX_SEG) ? MAX_SEG : pos_reg + 16'd1;
    end

    always_comb begin
        pos_next = pos_reg;
        if (in_accept) begin
            pos_next = in_last ? 16'd0 : cap_next.total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 16'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // Field captures are fully rewritten by any segment of 20 bytes or more
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cap_reg <= cap_next;
        end
    end

    assign push = in_accept & in_last;
    assign rec  = cap_next;

endmodule

FILE: design/tcphp_queue.sv
module tcphp_queue #(
    parameter int unsigned DEPTH = tcphp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tcphp_pkg::seg_rec_t push_data,
    input  logic                pop,
    output tcphp_pkg::seg_rec_t pop_data,
    output tcphp_pkg::q_stat_t  stat
);
    import tcphp_pkg::*;

    localparam int unsigned     AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned     CW       = $clog2(DEPTH + 1);
    localparam logic [AW-1:0]   LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0]   FULL_CNT = CW'(DEPTH);

    seg_rec_t      entry_reg [DEPTH];
    logic [AW-1:0] wr_idx_reg;
    logic [AW-1:0] wr_idx_next;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] rd_idx_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);

    // indexes wrap at DEPTH, so any depth works
    always_comb begin
        wr_idx_next = wr_idx_reg;
        if (push) begin
            wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
        end
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (pop) begin
            rd_idx_next = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
        end
    end

    assign count_next = count_reg + CW'(push) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_idx_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_idx_reg];

endmodule

FILE: design/tcphp_back.sv
module tcphp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rec_valid,
    input  tcphp_pkg::seg_rec_t rec,
    input  logic [5:0]          max_hdr,
    input  logic                out_ready,
    output logic                pop,
    output logic                out_valid,
    output tcphp_pkg::result_t  result
);
    import tcphp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    result_t     res_reg;
    result_t     res_next;
    logic        load;
    logic [3:0]  offs;
    logic [5:0]  hdr_len;

    assign load = rec_valid && (!valid_reg || out_ready);
    assign offs    = rec.off_flags[11:8];
    assign hdr_len = {offs, 2'b00};

    always_comb begin
        res_next = '0;
        if (rec.total < FIXED_HDR_BYTES) begin
            res_next.status = ST_TOO_SHORT;
        end else begin
            res_next.source_port     = rec.ports[31:16];
            res_next.dest_port       = rec.ports[15:0];
            res_next.sequence_number = rec.seq;
            res_next.ack_number      = rec.ack;
            res_next.offset_words    = offs;
            res_next.flag_bits       = rec.off_flags[7:0];
            res_next.window_size     = rec.win_csum[31:16];
            res_next.header_checksum = rec.win_csum[15:0];
            res_next.urgent_pointer  = rec.urgent;
            if (offs < MIN_OFFSET_WORDS || hdr_len > max_hdr) begin
                res_next.status = ST_BAD_HEADER;
            end else if (rec.total < {10'd0, hdr_len}) begin
                res_next.status = ST_TOO_SHORT;
            end else begin
                res_next.status        = ST_OK;
                res_next.options_bytes = hdr_len - FIXED_HDR_SHORT;
                res_next.payload_bytes = rec.total - {10'd0, hdr_len};
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign pop       = load;
    assign out_valid = valid_reg;
    assign result    = res_reg;

endmodule

FILE: design/tcphp_checker.sv
module tcphp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [183:0] m_tdata,
    input logic [1:0]   m_tuser
);
    import tcphp_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // too_short and bad_header never carry lengths
    a_no_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_TOO_SHORT || m_tuser == ST_BAD_HEADER)
        |-> m_tdata[177:156] == 22'd0)
        else $error("lengths given with a failing status");

    // ok status: offset at least five words and options match the offset
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_OK
        |-> m_tdata[99:96] >= MIN_OFFSET_WORDS &&
            m_tdata[161:156] == {m_tdata[99:96], 2'b00} - FIXED_HDR_SHORT)
        else $error("ok result with inconsistent header length");

    // status code 3 is never produced
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code");

endmodule

bind tcp_header_parser tcphp_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: sim/tcp_header_parser_tb.sv
module tcp_header_parser_tb;
    import tcphp_pkg::*;

    // Clock and reset
    logic         aclk    = 1'b0;
    logic         aresetn = 1'b0;

    // Byte stream into the parser
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;   // [7:0] seg_byte
    logic         s_tlast  = 1'b0;    // last_byte

    // Result stream out of the parser
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [183:0] m_tdata;            // source_port first, payload_bytes last, zero pad on top
    logic [1:0]   m_tuser;            // [1:0] status

    // APB
    logic         psel    = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite  = 1'b0;
    logic [2:0]   paddr   = 3'd0;
    logic [31:0]  pwdata  = 32'd0;
    logic [31:0]  prdata;
    logic         pready;

    // Register slot that decodes to nothing; writes there must be dropped
    localparam logic REG_UNMAPPED = 1'b1;

    // One directed segment. typed rows carry a hand-written expectation that
    // replaces the predicted one for that segment.
    typedef struct packed {
        bit          write_limit;
        logic [5:0]  limit;
        logic [16:0] seg_len;
        logic [3:0]  offs;
        logic [7:0]  fill;
        bit          scramble;
        bit          typed;
        status_t     want_status;
        logic [5:0]  want_opts;
        logic [15:0] want_payload;
    } seg_case_t;

    // Travels with each segment from the sender to the monitor
    typedef struct packed {
        bit      typed;
        result_t want;
    } seg_label_t;

    typedef enum logic [1:0] {
        SEG_NOISE,        // random length and content
        SEG_TRUNCATED,    // valid offset, ends inside the header
        SEG_WELL_FORMED   // header plus a short payload
    } seg_shape_t;

    // Predictor state: mirrors the parser's capture registers
    logic [15:0] rx_count     = '0;
    logic [31:0] port_cap     = '0;
    logic [31:0] seq_cap      = '0;
    logic [31:0] ack_cap      = '0;
    logic [11:0] offflag_cap  = '0;
    logic [31:0] wincsum_cap  = '0;
    logic [15:0] urgent_cap   = '0;
    logic [5:0]  hdr_limit    = MAX_HDR_RESET;

    result_t     pending_results[$];
    seg_label_t  seg_labels[$];
    seg_case_t   directed[$];

    // Idle knobs, percent chance of a random idle gap per transfer
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned hold_req     = 0;   // long receiver hold-off, in cycles

    int unsigned mismatch_count = 0;
    int unsigned segs_sent      = 0;
    int unsigned bytes_sent     = 0;
    int unsigned limit_writes   = 0;
    int unsigned ok_seen        = 0;
    int unsigned short_seen     = 0;
    int unsigned bad_seen       = 0;

    tcp_header_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Predictor: takes one byte, returns 1 with the result when the byte ends
    // a segment. Header bytes are shifted in big-endian; the length counter
    // saturates at the segment size limit.
    function automatic bit absorb_byte(input logic [7:0] b, input bit last,
                                       output result_t r);
        int unsigned pos;
        int unsigned total;
        int unsigned hdr;
        logic [3:0]  offs;
        r   = '0;
        pos = 32'(rx_count);
        if (pos < 4)
            port_cap = {port_cap[23:0], b};
        else if (pos < 8)
            seq_cap = {seq_cap[23:0], b};
        else if (pos < 12)
            ack_cap = {ack_cap[23:0], b};
        else if (pos == 12)
            offflag_cap[11:8] = b[7:4];
        else if (pos == 13)
            offflag_cap[7:0] = b;
        else if (pos < 18)
            wincsum_cap = {wincsum_cap[23:0], b};
        else if (pos < FIXED_HDR_BYTES)
            urgent_cap = {urgent_cap[7:0], b};
        total = (pos + 1 > MAX_SEG_BYTES_DEF) ? MAX_SEG_BYTES_DEF : pos + 1;
        rx_count = total[15:0];
        if (!last)
            return 1'b0;

        if (total < FIXED_HDR_BYTES) begin
            // runt: status only, everything else zero
            r.status = ST_TOO_SHORT;
        end else begin
            offs = offflag_cap[11:8];
            r.source_port     = port_cap[31:16];
            r.dest_port       = port_cap[15:0];
            r.sequence_number = seq_cap;
            r.ack_number      = ack_cap;
            r.offset_words    = offs;
            r.flag_bits       = offflag_cap[7:0];
            r.window_size     = wincsum_cap[31:16];
            r.header_checksum = wincsum_cap[15:0];
            r.urgent_pointer  = urgent_cap;
            hdr = int'(offs) * 4;
            if (offs < MIN_OFFSET_WORDS || hdr > hdr_limit)
                r.status = ST_BAD_HEADER;
            else if (total < hdr)
                r.status = ST_TOO_SHORT;
            else begin
                r.status        = ST_OK;
                r.options_bytes = 6'(hdr - FIXED_HDR_BYTES);
                r.payload_bytes = 16'(total - hdr);
            end
        end

        rx_count    = '0;
        port_cap    = '0;
        seq_cap     = '0;
        ack_cap     = '0;
        offflag_cap = '0;
        wincsum_cap = '0;
        urgent_cap  = '0;
        return 1'b1;
    endfunction

    // Monitor: result side first, so a result is never matched against an
    // expectation queued at the same edge.
    always @(posedge aclk) begin
        result_t    got;
        result_t    want;
        result_t    pred;
        seg_label_t lbl;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no segment outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    got  = '0;
                    got.status          = status_t'(m_tuser);
                    got.source_port     = m_tdata[15:0];
                    got.dest_port       = m_tdata[31:16];
                    got.sequence_number = m_tdata[63:32];
                    got.ack_number      = m_tdata[95:64];
                    got.offset_words    = m_tdata[99:96];
                    got.flag_bits       = m_tdata[107:100];
                    got.window_size     = m_tdata[123:108];
                    got.header_checksum = m_tdata[139:124];
                    got.urgent_pointer  = m_tdata[155:140];
                    got.options_bytes   = m_tdata[161:156];
                    got.payload_bytes   = m_tdata[177:162];
                    check_field("status", want.status, got.status);
                    check_field("source_port", want.source_port, got.source_port);
                    check_field("dest_port", want.dest_port, got.dest_port);
                    check_field("sequence_number", want.sequence_number,
                                got.sequence_number);
                    check_field("ack_number", want.ack_number, got.ack_number);
                    check_field("offset_words", want.offset_words, got.offset_words);
                    check_field("flag_bits", want.flag_bits, got.flag_bits);
                    check_field("window_size", want.window_size, got.window_size);
                    check_field("header_checksum", want.header_checksum,
                                got.header_checksum);
                    check_field("urgent_pointer", want.urgent_pointer,
                                got.urgent_pointer);
                    check_field("options_bytes", want.options_bytes, got.options_bytes);
                    check_field("payload_bytes", want.payload_bytes, got.payload_bytes);
                    check_field("tdata pad", 64'd0, m_tdata[183:178]);
                    case (want.status)
                        ST_OK:        ok_seen++;
                        ST_TOO_SHORT: short_seen++;
                        default:      bad_seen++;
                    endcase
                end
            end
            if (s_tvalid && s_tready) begin
                bytes_sent++;
                if (absorb_byte(s_tdata, s_tlast, pred)) begin
                    lbl = seg_labels.pop_front();
                    pending_results.push_back(lbl.typed ? lbl.want : pred);
                end
            end
        end
    end

    // Receiver: random short stalls, plus one long hold-off on request
    initial begin
        int unsigned n;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req != 0) begin
                n        = hold_req;
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (rcv_idle_pct != 0 && $urandom_range(0, 99) < rcv_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // One byte transfer; returns at the edge that accepted it
    task automatic push_byte(input logic [7:0] b, input bit last);
        if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_segment(input int unsigned len, input logic [3:0] offs,
                                input bit scramble, input logic [7:0] fill,
                                input seg_label_t lbl);
        logic [7:0] b;
        seg_labels.push_back(lbl);
        for (int unsigned i = 0; i < len; i++) begin
            b = scramble ? 8'($urandom_range(0, 255)) : fill;
            if (i == 12)
                b[7:4] = offs;
            push_byte(b, i == len - 1);
        end
        segs_sent++;
    endtask

    // Stop offering bytes and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (seg_labels.size() != 0 || pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        if (wr && addr[2] == REG_MAX_HDR)
            hdr_limit = wdata[5:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_back_limit();
        logic [31:0] rd;
        apb_access(1'b0, {REG_MAX_HDR, 2'b00}, 32'd0, rd);
        check_field("max_header_bytes", hdr_limit, rd[5:0]);
    endtask

    task automatic set_hdr_limit(input logic [5:0] v);
        logic [31:0] rd;
        drain_results();
        // upper bits of pwdata are junk on purpose; only [5:0] is kept
        apb_access(1'b1, {REG_MAX_HDR, 2'b00},
                   {26'($urandom_range(0, 32'h03FF_FFFF)), v}, rd);
        limit_writes++;
        read_back_limit();
    endtask

    function automatic seg_case_t mk_case(input bit wr_lim, input logic [5:0] lim,
                                          input int unsigned len, input logic [3:0] offs,
                                          input logic [7:0] fill, input bit scramble,
                                          input bit typed, input status_t st,
                                          input logic [5:0] opts, input logic [15:0] pay);
        seg_case_t c;
        c.write_limit  = wr_lim;
        c.limit        = lim;
        c.seg_len      = 17'(len);
        c.offs         = offs;
        c.fill         = fill;
        c.scramble     = scramble;
        c.typed        = typed;
        c.want_status  = st;
        c.want_opts    = opts;
        c.want_payload = pay;
        return c;
    endfunction

    // Stimulus
    initial begin
        seg_case_t   c;
        seg_label_t  lbl;
        seg_shape_t  shape;
        logic [31:0] rd;
        logic [7:0]  f;
        logic [3:0]  offs;
        int unsigned len;
        int unsigned phase_bytes;
        logic [5:0]  phase_limit [6];
        int unsigned phase_snd   [6];
        int unsigned phase_rcv   [6];

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register must come out of reset at its default
        read_back_limit();

        //                 wr  lim  len   off fill   scr typ status         opt pay
        // runts: status only
        directed.push_back(mk_case(0, 0, 1,     0, 8'hFF, 0, 1, ST_TOO_SHORT,  0, 0));
        directed.push_back(mk_case(0, 0, 19,    0, 8'hFF, 0, 1, ST_TOO_SHORT,  0, 0));
        // bare 20-byte headers, all-zero and all-one content
        directed.push_back(mk_case(0, 0, 20,    5, 8'h00, 0, 1, ST_OK,         0, 0));
        directed.push_back(mk_case(0, 0, 20,    5, 8'hFF, 0, 1, ST_OK,         0, 0));
        // offset below five words
        directed.push_back(mk_case(0, 0, 20,    4, 8'hAA, 0, 1, ST_BAD_HEADER, 0, 0));
        directed.push_back(mk_case(0, 0, 20,    0, 8'h00, 0, 1, ST_BAD_HEADER, 0, 0));
        // largest header, exactly filling the segment
        directed.push_back(mk_case(0, 0, 60,   15, 8'h00, 0, 1, ST_OK,        40, 0));
        // segment ends inside the options
        directed.push_back(mk_case(0, 0, 23,    6, 8'h55, 0, 1, ST_TOO_SHORT,  0, 0));
        directed.push_back(mk_case(0, 0, 100,   8, 8'h00, 1, 0, ST_OK,         0, 0));
        // tightest limit: any option makes the header too long
        directed.push_back(mk_case(1, 20, 24,   6, 8'h00, 0, 1, ST_BAD_HEADER, 0, 0));
        directed.push_back(mk_case(0, 0, 21,    5, 8'hFF, 0, 1, ST_OK,         0, 1));
        // limit below the fixed header rejects everything
        directed.push_back(mk_case(1, 0, 20,    5, 8'h00, 0, 1, ST_BAD_HEADER, 0, 0));
        directed.push_back(mk_case(1, 63, 64,  15, 8'h00, 1, 0, ST_OK,         0, 0));
        // length counter saturates; payload comes from the clamped length
        directed.push_back(mk_case(1, 60, 65600, 5, 8'h00, 0, 1, ST_OK,        0, 16'd65515));
        directed.push_back(mk_case(0, 0, 40,   10, 8'h00, 1, 0, ST_OK,         0, 0));

        snd_idle_pct = 15;
        rcv_idle_pct = 15;
        foreach (directed[i]) begin
            c = directed[i];
            if (c.write_limit)
                set_hdr_limit(c.limit);
            lbl = '0;
            if (c.typed) begin
                lbl.typed       = 1'b1;
                lbl.want.status = c.want_status;
                if (c.seg_len >= FIXED_HDR_BYTES) begin
                    f = c.fill;
                    lbl.want.source_port     = {f, f};
                    lbl.want.dest_port       = {f, f};
                    lbl.want.sequence_number = {f, f, f, f};
                    lbl.want.ack_number      = {f, f, f, f};
                    lbl.want.offset_words    = c.offs;
                    lbl.want.flag_bits       = f;
                    lbl.want.window_size     = {f, f};
                    lbl.want.header_checksum = {f, f};
                    lbl.want.urgent_pointer  = {f, f};
                end
                lbl.want.options_bytes = c.want_opts;
                lbl.want.payload_bytes = c.want_payload;
            end
            // keep the long segment quick
            snd_idle_pct = (c.seg_len > 1000) ? 0 : 15;
            send_segment(c.seg_len, c.offs, c.scramble, c.fill, lbl);
        end

        // write to an unmapped slot must leave the limit alone
        drain_results();
        apb_access(1'b1, {REG_UNMAPPED, 2'b00}, 32'd20, rd);
        read_back_limit();

        // back-pressure: receiver holds off while one-byte runts keep coming,
        // so the record queue fills and s_tready drops
        snd_idle_pct = 0;
        hold_req     = 60;
        repeat (16) begin
            len = 1;
            send_segment(len, 4'd0, 1'b1, 8'h00, '0);
        end
        drain_results();

        // random phases; the last one has no idling at all
        phase_limit = '{6'd60, 6'd20, 6'd63, 6'd0, 6'(40 + $urandom_range(0, 19)), 6'd60};
        phase_snd   = '{20, 25, 0, 20, 15, 0};
        phase_rcv   = '{20, 0, 25, 20, 15, 0};
        for (int p = 0; p < 6; p++) begin
            set_hdr_limit(phase_limit[p]);
            snd_idle_pct = phase_snd[p];
            rcv_idle_pct = phase_rcv[p];
            phase_bytes  = 0;
            while (phase_bytes < 340) begin
                case ($urandom_range(0, 9))
                    0:       shape = SEG_NOISE;
                    1:       shape = SEG_TRUNCATED;
                    default: shape = SEG_WELL_FORMED;
                endcase
                case (shape)
                    SEG_NOISE: begin
                        offs = 4'($urandom_range(0, 15));
                        len  = $urandom_range(1, 30);
                    end
                    SEG_TRUNCATED: begin
                        offs = 4'($urandom_range(6, 15));
                        len  = $urandom_range(FIXED_HDR_BYTES, int'(offs) * 4 - 1);
                    end
                    default: begin
                        offs = 4'($urandom_range(5, 15));
                        len  = int'(offs) * 4 + $urandom_range(0, 24);
                    end
                endcase
                send_segment(len, offs, 1'b1, 8'h00, '0);
                phase_bytes += len;
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);

        $display("Sent %0d segments (%0d bytes) under %0d header-limit settings",
                 segs_sent, bytes_sent, limit_writes);
        $display("Checked results: %0d ok, %0d too short, %0d bad header",
                 ok_seen, short_seen, bad_seen);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
